>>> rtl/core/kmst_pkg.sv
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared types and sizes for the Kruskal spanning tree block.
// ----------------------------------------------------------------------------
package kmst_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;
  localparam int WEIGHT_BITS  = 16;

  localparam int VERT_W   = 7;
  localparam int VIDX_W   = $clog2(MAX_VERTICES);
  localparam int EIDX_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CNT_W    = $clog2(MAX_EDGES + 1);
  localparam int CHOSEN_W = $clog2(MAX_VERTICES);
  localparam int RANK_W   = 3;
  localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

  localparam logic [VERT_W-1:0] VCOUNT_RESET = 7'd64;
  localparam logic [VERT_W-1:0] VCOUNT_MAX   = VERT_W'(MAX_VERTICES);

  typedef struct packed {
    logic [VERT_W-1:0]             src;
    logic [VERT_W-1:0]             dst;
    logic signed [WEIGHT_BITS-1:0] wt;
  } edge_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [VERT_W-1:0] parent;
  } uf_ent_t;

  // forest request/response between the top level and the union-find unit
  typedef struct packed {
    logic              clear;
    logic              go;
    logic [VERT_W-1:0] src;
    logic [VERT_W-1:0] dst;
  } uf_req_t;

  typedef struct packed {
    logic done;
    logic joined;
  } uf_rsp_t;

endpackage

>>> rtl/core/kmst_if.sv
// ----------------------------------------------------------------------------
// kmst_if
// Valid/ready channels of the spanning tree block.
// ----------------------------------------------------------------------------
interface kmst_edge_if import kmst_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [VERT_W-1:0]             src_vertex;
  logic [VERT_W-1:0]             dst_vertex;
  logic signed [WEIGHT_BITS-1:0] edge_weight;
  logic                          last_edge;
  modport source (output valid, src_vertex, dst_vertex, edge_weight, last_edge, input ready);
  modport sink   (input valid, src_vertex, dst_vertex, edge_weight, last_edge, output ready);
endinterface

interface kmst_result_if import kmst_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [VERT_W-1:0]             tree_src;
  logic [VERT_W-1:0]             tree_dst;
  logic signed [WEIGHT_BITS-1:0] tree_weight;
  logic                          edge_valid;
  logic                          tree_complete;
  logic                          input_dropped;
  logic                          last_result;
  modport source (output valid, tree_src, tree_dst, tree_weight, edge_valid,
                  tree_complete, input_dropped, last_result, input ready);
  modport sink   (input valid, tree_src, tree_dst, tree_weight, edge_valid,
                  tree_complete, input_dropped, last_result, output ready);
endinterface

interface kmst_cfg_if import kmst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VERT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/core/kmst_sorter.sv
// ----------------------------------------------------------------------------
// kmst_sorter
// Edge memory kept in weight order by insertion, one shift per cycle.
// ----------------------------------------------------------------------------
module kmst_sorter import kmst_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [EIDX_W-1:0] pos,
  input  edge_t             new_edge,
  input  logic [EIDX_W-1:0] walk_addr,
  output edge_t             rd_edge,
  output logic              busy
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_PUT  = 3'b100
  } sort_state_t;

  sort_state_t       state_r, state_nxt;
  logic [EIDX_W-1:0] j_r, j_nxt;
  edge_t             key_r, key_nxt;
  edge_t             mem [MAX_EDGES];
  edge_t             rd_r;
  logic [EIDX_W-1:0] raddr;
  logic              we;
  logic [EIDX_W-1:0] waddr;
  edge_t             wdata;

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    key_nxt   = key_r;
    raddr     = walk_addr;
    we        = 1'b0;
    waddr     = j_r;
    wdata     = key_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt = new_edge;
          if (pos == '0) begin
            we    = 1'b1;
            waddr = '0;
            wdata = new_edge;
          end else begin
            j_nxt     = pos;
            raddr     = pos - 1'b1;
            state_nxt = S_CMP;
          end
        end
      end
      S_CMP: begin
        we = 1'b1;
        if (rd_r.wt > key_r.wt) begin
          // shift the heavier edge up one slot
          wdata = rd_r;
          j_nxt = j_r - 1'b1;
          if (j_r == EIDX_W'(1)) begin
            state_nxt = S_PUT;
          end else begin
            raddr = j_r - EIDX_W'(2);
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PUT: begin
        we        = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    j_r   <= j_nxt;
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  assign rd_edge = rd_r;
  assign busy    = (state_r != S_IDLE);

endmodule

>>> rtl/core/kmst_forest.sv
// ----------------------------------------------------------------------------
// kmst_forest
// Union-find forest with union by rank; one find step per cycle.
// ----------------------------------------------------------------------------
module kmst_forest import kmst_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  uf_req_t req,
  output uf_rsp_t rsp
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_FA   = 5'b00010,
    F_FB   = 5'b00100,
    F_BUMP = 5'b01000,
    F_DONE = 5'b10000
  } uf_state_t;

  uf_state_t         state_r, state_nxt;
  logic [VERT_W-1:0] cur_r, cur_nxt;
  logic [VERT_W-1:0] dst_r, dst_nxt;
  logic [VERT_W-1:0] xroot_r, xroot_nxt;
  logic [RANK_W-1:0] xrank_r, xrank_nxt;
  logic              joined_r, joined_nxt;
  uf_ent_t           mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] vld_r;
  uf_ent_t           rd_r;
  logic              rvld_r;
  logic [VIDX_W-1:0] raddr;
  logic              we;
  logic [VIDX_W-1:0] waddr;
  uf_ent_t           wdata;
  uf_ent_t           ent;

  // an entry never written since clear is its own root with rank zero
  always_comb begin
    ent = rd_r;
    if (!rvld_r) begin
      ent.parent = cur_r;
      ent.rank   = '0;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    dst_nxt    = dst_r;
    xroot_nxt  = xroot_r;
    xrank_nxt  = xrank_r;
    joined_nxt = joined_r;
    raddr      = VIDX_W'(cur_r - 1'b1);
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    unique case (state_r)
      F_IDLE: begin
        if (req.go) begin
          cur_nxt   = req.src;
          dst_nxt   = req.dst;
          raddr     = VIDX_W'(req.src - 1'b1);
          state_nxt = F_FA;
        end
      end
      F_FA: begin
        if (ent.parent == cur_r) begin
          xroot_nxt = cur_r;
          xrank_nxt = ent.rank;
          cur_nxt   = dst_r;
          raddr     = VIDX_W'(dst_r - 1'b1);
          state_nxt = F_FB;
        end else begin
          cur_nxt = ent.parent;
          raddr   = VIDX_W'(ent.parent - 1'b1);
        end
      end
      F_FB: begin
        if (ent.parent == cur_r) begin
          if (cur_r == xroot_r) begin
            joined_nxt = 1'b0;
            state_nxt  = F_DONE;
          end else begin
            joined_nxt = 1'b1;
            we         = 1'b1;
            if (xrank_r < ent.rank) begin
              waddr     = VIDX_W'(xroot_r - 1'b1);
              wdata     = '{rank: xrank_r, parent: cur_r};
              state_nxt = F_DONE;
            end else begin
              waddr     = VIDX_W'(cur_r - 1'b1);
              wdata     = '{rank: ent.rank, parent: xroot_r};
              state_nxt = (xrank_r == ent.rank) ? F_BUMP : F_DONE;
            end
          end
        end else begin
          cur_nxt = ent.parent;
          raddr   = VIDX_W'(ent.parent - 1'b1);
        end
      end
      F_BUMP: begin
        we    = 1'b1;
        waddr = VIDX_W'(xroot_r - 1'b1);
        wdata = '{rank: (xrank_r < RANK_MAX) ? xrank_r + 1'b1 : xrank_r, parent: xroot_r};
        state_nxt = F_DONE;
      end
      F_DONE: state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (req.clear) begin
        vld_r <= '0;
      end else if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
    cur_r    <= cur_nxt;
    dst_r    <= dst_nxt;
    xroot_r  <= xroot_nxt;
    xrank_r  <= xrank_nxt;
    joined_r <= joined_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r   <= mem[raddr];
    rvld_r <= vld_r[raddr] && !(we && waddr == raddr);
  end

  assign rsp.done   = (state_r == F_DONE);
  assign rsp.joined = joined_r;

endmodule

>>> rtl/core/minimum_spanning_tree_kruskal.sv
// ----------------------------------------------------------------------------
// minimum_spanning_tree_kruskal
// Kruskal minimum spanning tree over a loaded edge list.
// ----------------------------------------------------------------------------
// Edges are taken one per item. Each kept edge is inserted into a weight-ordered
// edge memory, one slot shift per cycle, and the next edge is taken only once
// the insertion is done. After the edge marked last the sorted edges are
// walked: each takes one memory read, find steps for each end in the
// union-find memory, and up to two writes to merge. Results leave through an
// output register; a chosen edge is held until the next chosen edge or the end
// of the walk shows whether it is the last.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_kruskal import kmst_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  kmst_edge_if.sink     in_edge,
  kmst_result_if.source out_tree,
  kmst_cfg_if.sink      cfg_wr
);

  typedef enum logic [6:0] {
    T_LOAD  = 7'b0000001,
    T_SORTW = 7'b0000010,
    T_RD    = 7'b0000100,
    T_EDGE  = 7'b0001000,
    T_UF    = 7'b0010000,
    T_EMIT  = 7'b0100000,
    T_FIN   = 7'b1000000
  } top_state_t;

  top_state_t          state_r, state_nxt;
  logic [VERT_W-1:0]   vcount_r;
  logic [VERT_W-1:0]   n_eff;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CHOSEN_W-1:0] chosen_r, chosen_nxt;
  logic                drop_r, drop_nxt;
  logic                last_r, last_nxt;
  edge_t               cur_r, cur_nxt;
  edge_t               pend_r, pend_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic                out_vld_r, out_vld_nxt;
  edge_t               oe_r, oe_nxt;
  logic                oev_r, oev_nxt;
  logic                ocpl_r, ocpl_nxt;
  logic                odrop_r, odrop_nxt;
  logic                olast_r, olast_nxt;
  logic                accept, keep, out_free, walk_end;
  logic                sort_start, sort_busy;
  edge_t               in_e, rd_edge;
  uf_req_t             uf_req;
  uf_rsp_t             uf_rsp;
  logic [CNT_W-1:0]    idx_inc;
  logic [CHOSEN_W-1:0] chosen_inc;

  assign n_eff = (vcount_r == '0) ? VERT_W'(1) :
                 (vcount_r > VCOUNT_MAX) ? VCOUNT_MAX : vcount_r;

  assign in_e = '{src: in_edge.src_vertex, dst: in_edge.dst_vertex, wt: in_edge.edge_weight};
  assign in_edge.ready = (state_r == T_LOAD);
  assign cfg_wr.ready  = 1'b1;
  assign accept   = in_edge.valid && in_edge.ready;
  assign keep     = (in_e.src != '0) && (in_e.src <= n_eff) &&
                    (in_e.dst != '0) && (in_e.dst <= n_eff) &&
                    (cnt_r < CNT_W'(MAX_EDGES));
  assign out_free = !out_vld_r || out_tree.ready;
  assign idx_inc    = idx_r + 1'b1;
  assign chosen_inc = chosen_r + 1'b1;

  kmst_sorter u_sorter (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (sort_start),
    .pos       (cnt_r[EIDX_W-1:0]),
    .new_edge  (in_e),
    .walk_addr (idx_r[EIDX_W-1:0]),
    .rd_edge   (rd_edge),
    .busy      (sort_busy)
  );

  kmst_forest u_forest (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (uf_req),
    .rsp   (uf_rsp)
  );

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    chosen_nxt   = chosen_r;
    drop_nxt     = drop_r;
    last_nxt     = last_r;
    cur_nxt      = cur_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    out_vld_nxt  = out_vld_r && !out_tree.ready;
    oe_nxt       = oe_r;
    oev_nxt      = oev_r;
    ocpl_nxt     = ocpl_r;
    odrop_nxt    = odrop_r;
    olast_nxt    = olast_r;
    sort_start   = 1'b0;
    uf_req       = '{clear: 1'b0, go: 1'b0, src: cur_r.src, dst: cur_r.dst};
    walk_end     = 1'b0;
    unique case (state_r)
      T_LOAD: begin
        if (accept) begin
          last_nxt = in_edge.last_edge;
          if (keep) begin
            sort_start = 1'b1;
            cnt_nxt    = cnt_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (keep || in_edge.last_edge) begin
            state_nxt = T_SORTW;
          end
        end
      end
      T_SORTW: begin
        if (!sort_busy) begin
          if (last_r) begin
            uf_req.clear = 1'b1;
            idx_nxt      = '0;
            chosen_nxt   = '0;
            pend_vld_nxt = 1'b0;
            state_nxt    = (cnt_r == '0) ? T_FIN : T_RD;
          end else begin
            state_nxt = T_LOAD;
          end
        end
      end
      T_RD: state_nxt = T_EDGE;
      T_EDGE: begin
        cur_nxt   = rd_edge;
        state_nxt = T_UF;
      end
      T_UF: begin
        uf_req.go = 1'b1;
        if (uf_rsp.done) begin
          uf_req.go = 1'b0;
          if (uf_rsp.joined) begin
            state_nxt = T_EMIT;
          end else begin
            walk_end = 1'b1;
          end
        end
      end
      T_EMIT: begin
        // push the held edge out before holding the new one
        if (!pend_vld_r || out_free) begin
          if (pend_vld_r) begin
            out_vld_nxt = 1'b1;
            oe_nxt      = pend_r;
            oev_nxt     = 1'b1;
            ocpl_nxt    = 1'b0;
            odrop_nxt   = drop_r;
            olast_nxt   = 1'b0;
          end
          pend_nxt     = cur_r;
          pend_vld_nxt = 1'b1;
          chosen_nxt   = chosen_inc;
          walk_end     = 1'b1;
        end
      end
      T_FIN: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          oe_nxt       = pend_vld_r ? pend_r : '0;
          oev_nxt      = pend_vld_r;
          ocpl_nxt     = (VERT_W'(chosen_r) == n_eff - 1'b1);
          odrop_nxt    = drop_r;
          olast_nxt    = 1'b1;
          pend_vld_nxt = 1'b0;
          cnt_nxt      = '0;
          drop_nxt     = 1'b0;
          last_nxt     = 1'b0;
          state_nxt    = T_LOAD;
        end
      end
      default: state_nxt = T_LOAD;
    endcase
    if (walk_end) begin
      idx_nxt = idx_inc;
      if (idx_inc == cnt_r || chosen_nxt == CHOSEN_W'(MAX_VERTICES - 1)) begin
        state_nxt = T_FIN;
      end else begin
        state_nxt = T_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= T_LOAD;
      vcount_r   <= VCOUNT_RESET;
      cnt_r      <= '0;
      drop_r     <= 1'b0;
      last_r     <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      idx_r      <= '0;
      chosen_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      if (cfg_wr.valid && cfg_wr.ready) begin
        vcount_r <= cfg_wr.data;
      end
      cnt_r      <= cnt_nxt;
      drop_r     <= drop_nxt;
      last_r     <= last_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      idx_r      <= idx_nxt;
      chosen_r   <= chosen_nxt;
    end
    cur_r   <= cur_nxt;
    pend_r  <= pend_nxt;
    oe_r    <= oe_nxt;
    oev_r   <= oev_nxt;
    ocpl_r  <= ocpl_nxt;
    odrop_r <= odrop_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tree.valid         = out_vld_r;
  assign out_tree.tree_src      = oe_r.src;
  assign out_tree.tree_dst      = oe_r.dst;
  assign out_tree.tree_weight   = oe_r.wt;
  assign out_tree.edge_valid    = oev_r;
  assign out_tree.tree_complete = ocpl_r;
  assign out_tree.input_dropped = odrop_r;
  assign out_tree.last_result   = olast_r;

endmodule

>>> rtl/core/kmst_checker.sv
// ----------------------------------------------------------------------------
// kmst_checker
// Port-level checks of the spanning tree block, bound to the top level.
// ----------------------------------------------------------------------------
module kmst_checker import kmst_pkg::*; (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [VERT_W-1:0]             out_src,
  input logic signed [WEIGHT_BITS-1:0] out_weight,
  input logic                          out_edge_valid,
  input logic                          out_complete,
  input logic                          out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_src) && $stable(out_weight))
    else $error("result changed while stalled");

  a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken right after the last edge");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_edge_valid |-> out_last)
    else $error("empty result not marked last");

  a_complete_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_complete |-> out_last)
    else $error("completeness flag before the last result");

endmodule

bind minimum_spanning_tree_kruskal kmst_checker u_kmst_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_edge.valid),
  .in_ready       (in_edge.ready),
  .in_last        (in_edge.last_edge),
  .out_valid      (out_tree.valid),
  .out_ready      (out_tree.ready),
  .out_src        (out_tree.tree_src),
  .out_weight     (out_tree.tree_weight),
  .out_edge_valid (out_tree.edge_valid),
  .out_complete   (out_tree.tree_complete),
  .out_last       (out_tree.last_result)
);
